// File: hdl/adaptive_residency_bucketer_top_defines.svh
// ----------------------------------------------------------------------------
// Adaptive residency bucketer: assertion macros
// Shared property wrappers for the checker; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_RESIDENCY_BUCKETER_TOP_DEFINES_SVH
`define ADAPTIVE_RESIDENCY_BUCKETER_TOP_DEFINES_SVH

// checked only out of reset
`define ARB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ARB_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/arb_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer package
// Widths, codes, sequencer states and the bucket record shared by the RTL.
// ----------------------------------------------------------------------------
package arb_pkg;

	localparam int DEFAULT_MAX_BUCKETS = 256;
	localparam int DEFAULT_CNT_W       = $clog2(DEFAULT_MAX_BUCKETS + 2);

	localparam int REQ_W      = 2;
	localparam int ID_W       = 32;
	localparam int CNT48_W    = 48;
	localparam int LIMIT_W    = 9;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

	typedef enum logic [REQ_W-1:0] {
		REQ_FILE_START = 2'd0,
		REQ_PAGE       = 2'd1,
		REQ_READ       = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKET_LIMIT = 1'b0,
		REG_INIT_PAGES   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_MRG_A,
		ST_MRG_B,
		ST_MRG_WR,
		ST_REREAD
	} state_t;

	typedef struct packed {
		logic [CNT48_W-1:0] pages;
		logic [CNT48_W-1:0] resid;
		logic [ID_W-1:0]    files;
		logic [ID_W-1:0]    sfile;
		logic [ID_W-1:0]    soff;
		logic               known;
	} bucket_t;

endpackage

// File: hdl/arb_in_if.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface arb_in_if #(
	parameter int CNT_W = arb_pkg::DEFAULT_CNT_W
) ();
	import arb_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [ID_W-1:0]  file_id;
	logic             resident;
	logic [CNT_W-1:0] bucket_index;

	modport source (output valid, req_type, file_id, resident, bucket_index, input ready);
	modport sink   (input valid, req_type, file_id, resident, bucket_index, output ready);
endinterface

// File: hdl/arb_out_if.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface arb_out_if #(
	parameter int CNT_W = arb_pkg::DEFAULT_CNT_W
) ();
	import arb_pkg::*;

	logic               valid;
	logic               ready;
	logic [CNT_W-1:0]   bucket_count;
	logic [CNT48_W-1:0] bucket_capacity;
	logic               index_valid;
	logic [CNT48_W-1:0] bucket_pages;
	logic [CNT48_W-1:0] bucket_resident;
	logic [ID_W-1:0]    bucket_files;
	logic [ID_W-1:0]    bucket_start_file;
	logic [ID_W-1:0]    bucket_start_offset;
	logic               bucket_has_start;
	logic [ID_W-1:0]    last_file_seen;

	modport source (
		output valid, bucket_count, bucket_capacity, index_valid, bucket_pages,
		bucket_resident, bucket_files, bucket_start_file, bucket_start_offset,
		bucket_has_start, last_file_seen,
		input ready
	);
	modport sink (
		input valid, bucket_count, bucket_capacity, index_valid, bucket_pages,
		bucket_resident, bucket_files, bucket_start_file, bucket_start_offset,
		bucket_has_start, last_file_seen,
		output ready
	);
endinterface

// File: hdl/arb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module arb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/arb_alu.sv
// ----------------------------------------------------------------------------
// Bucket adder
// Saturating field-wise add of two bucket records; start fields follow a.
// ----------------------------------------------------------------------------
module arb_alu (
	input  arb_pkg::bucket_t a,
	input  arb_pkg::bucket_t b,
	output arb_pkg::bucket_t y
);
	import arb_pkg::*;

	logic [CNT48_W:0] pages_sum;
	logic [CNT48_W:0] resid_sum;
	logic [ID_W:0]    files_sum;

	always_comb begin
		pages_sum = {1'b0, a.pages} + {1'b0, b.pages};
		resid_sum = {1'b0, a.resid} + {1'b0, b.resid};
		files_sum = {1'b0, a.files} + {1'b0, b.files};

		y       = a;
		y.pages = pages_sum[CNT48_W] ? '1 : pages_sum[CNT48_W-1:0];
		y.resid = resid_sum[CNT48_W] ? '1 : resid_sum[CNT48_W-1:0];
		y.files = files_sum[ID_W] ? '1 : files_sum[ID_W-1:0];
	end
endmodule

// File: hdl/adaptive_residency_bucketer_top.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer
// Bounded per-bucket page residency summary with pairwise bucket merging.
// ----------------------------------------------------------------------------
// A request is latched on transfer, run in ST_EXEC and its result registered
// from ST_RESP; the next one is taken back in ST_IDLE, later while the sink
// holds a result. A page that overflows at the bucket limit adds a merge pass:
// read, read, write per merged pair (single bucket RAM), then a re-read.
// Reset is asynchronous; bucket 0 reads as empty until first written, no
// clearing pass, so requests are taken on the first cycle out of reset.
// ----------------------------------------------------------------------------
module adaptive_residency_bucketer_top #(
	parameter int MAX_BUCKETS = arb_pkg::DEFAULT_MAX_BUCKETS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [arb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	arb_in_if.sink                         in_ch,
	arb_out_if.source                      out_ch
);
	import arb_pkg::*;

	localparam int DEPTH  = MAX_BUCKETS + 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] MAXB_C    = CNT_W'(MAX_BUCKETS);
	localparam logic [CNT_W-1:0] LIM_MIN_C = CNT_W'(2);

	state_t state_q, state_d;

	// latched request
	req_t             req_q;
	logic [ID_W-1:0]  fid_q;
	logic             res_q;
	logic [CNT_W-1:0] idx_q;

	logic [CNT_W-1:0]   used_q;
	logic [CNT48_W-1:0] cap_q;
	logic [ID_W-1:0]    pif_q;
	logic [ID_W-1:0]    cur_file_q;
	logic [LIMIT_W-1:0] lim_q;
	logic               zvalid_q;
	logic               merged_q;
	logic               rd_zero_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   npairs_q;
	bucket_t            a_q;
	bucket_t            rd_rec_q;
	logic               iv_q;

	logic               out_valid_q;
	logic [CNT_W-1:0]   out_count_q;
	logic [CNT48_W-1:0] out_cap_q;
	logic               out_iv_q;
	bucket_t            out_rec_q;
	logic [ID_W-1:0]    out_last_q;

	// RAM port
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	bucket_t             ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [$bits(bucket_t)-1:0] ram_rdata;

	bucket_t rdata_eff;
	bucket_t alu_a, alu_b, alu_y;
	bucket_t page_b, file_b, file_rec, open_rec;

	logic [ADDR_W-1:0]  last_addr;
	logic [CNT_W-1:0]   lim_eff;
	logic               full;
	logic [CNT_W-1:0]   a_idx, b_idx;
	logic               b_missing;
	logic               pad;
	logic [CNT_W:0]     npairs_sum;
	logic [CNT48_W-1:0] cap_dbl;
	logic               read_ok;

	logic take_item, pif_inc, do_open, do_file_start;
	logic merge_start, pair_step, merge_end, capture_a, load_out;

	arb_ram #(
		.WIDTH($bits(bucket_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	arb_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.y(alu_y)
	);

	always_comb begin
		rdata_eff  = rd_zero_q ? '0 : bucket_t'(ram_rdata);
		last_addr  = ADDR_W'(used_q - CNT_W'(1));
		full       = rdata_eff.pages >= cap_q;
		a_idx      = CNT_W'({k_q, 1'b0});
		b_idx      = a_idx | CNT_W'(1);
		b_missing  = b_idx == used_q;
		// odd count gets an empty neighbour unless the store is already full
		pad        = used_q[0] && (used_q != DEPTH_C);
		npairs_sum = {1'b0, used_q} + {{CNT_W{1'b0}}, pad};
		cap_dbl    = cap_q[CNT48_W-1] ? '1 : {cap_q[CNT48_W-2:0], 1'b0};
		read_ok    = (req_q == REQ_READ) && (idx_q < used_q);

		if (32'(lim_q) < 32'(2)) begin
			lim_eff = LIM_MIN_C;
		end else if (32'(lim_q) > 32'(MAX_BUCKETS)) begin
			lim_eff = MAXB_C;
		end else begin
			lim_eff = CNT_W'(lim_q);
		end
	end

	always_comb begin
		page_b       = '0;
		page_b.pages = CNT48_W'(1);
		page_b.resid = CNT48_W'(res_q);

		file_b       = '0;
		file_b.files = ID_W'(1);

		open_rec       = '0;
		open_rec.pages = CNT48_W'(1);
		open_rec.resid = CNT48_W'(res_q);
		open_rec.sfile = cur_file_q;
		open_rec.soff  = pif_q;
		open_rec.known = 1'b1;

		if (state_q == ST_MRG_WR) begin
			alu_a = a_q;
			alu_b = b_missing ? '0 : rdata_eff;
		end else begin
			alu_a = rdata_eff;
			alu_b = (req_q == REQ_FILE_START) ? file_b : page_b;
		end

		file_rec = alu_y;
		if (!rdata_eff.known) begin
			file_rec.sfile = fid_q;
			file_rec.soff  = '0;
			file_rec.known = 1'b1;
		end
	end

	// sequencer
	always_comb begin
		state_d       = state_q;
		in_ch.ready   = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = last_addr;
		ram_wdata     = alu_y;
		ram_raddr     = last_addr;
		take_item     = 1'b0;
		pif_inc       = 1'b0;
		do_open       = 1'b0;
		do_file_start = 1'b0;
		merge_start   = 1'b0;
		pair_step     = 1'b0;
		merge_end     = 1'b0;
		capture_a     = 1'b0;
		load_out      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.req_type == REQ_READ) begin
					ram_raddr = in_ch.bucket_index[ADDR_W-1:0];
				end
				if (in_ch.valid) begin
					take_item = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_RESP;
				unique case (req_q)
					REQ_FILE_START: begin
						ram_we        = 1'b1;
						ram_wdata     = file_rec;
						do_file_start = 1'b1;
					end
					REQ_PAGE: begin
						if (!full) begin
							ram_we  = 1'b1;
							pif_inc = 1'b1;
						end else if (!merged_q && (used_q >= lim_eff)) begin
							merge_start = 1'b1;
							state_d     = ST_MRG_A;
						end else if (used_q != DEPTH_C) begin
							ram_we    = 1'b1;
							ram_waddr = ADDR_W'(used_q);
							ram_wdata = open_rec;
							do_open   = 1'b1;
							pif_inc   = 1'b1;
						end else begin
							// no room to open: keep adding to the last bucket
							ram_we  = 1'b1;
							pif_inc = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			ST_MRG_A: begin
				ram_raddr = a_idx[ADDR_W-1:0];
				state_d   = ST_MRG_B;
			end
			ST_MRG_B: begin
				ram_raddr = b_idx[ADDR_W-1:0];
				capture_a = 1'b1;
				state_d   = ST_MRG_WR;
			end
			ST_MRG_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[ADDR_W-1:0];
				if ((k_q + CNT_W'(1)) == npairs_q) begin
					merge_end = 1'b1;
					state_d   = ST_REREAD;
				end else begin
					pair_step = 1'b1;
					state_d   = ST_MRG_A;
				end
			end
			ST_REREAD: begin
				state_d = ST_EXEC;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= CNT_W'(1);
			cap_q       <= CNT48_W'(1);
			pif_q       <= '0;
			cur_file_q  <= '0;
			lim_q       <= LIMIT_RESET;
			zvalid_q    <= 1'b0;
			merged_q    <= 1'b0;
			rd_zero_q   <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_zero_q <= (ram_raddr == '0) && !zvalid_q;

			if (ram_we && (ram_waddr == '0)) begin
				zvalid_q <= 1'b1;
			end

			if (cfg_we && (cfg_index == REG_BUCKET_LIMIT)) begin
				lim_q <= cfg_wdata[LIMIT_W-1:0];
			end

			if (cfg_we && (cfg_index == REG_INIT_PAGES)) begin
				cap_q <= (cfg_wdata == '0) ? CNT48_W'(1) : CNT48_W'(cfg_wdata);
			end else if (merge_end) begin
				cap_q <= cap_dbl;
			end

			if (merge_end) begin
				used_q <= npairs_q;
			end else if (do_open) begin
				used_q <= used_q + CNT_W'(1);
			end

			if (do_file_start) begin
				pif_q      <= '0;
				cur_file_q <= fid_q;
			end else if (pif_inc) begin
				pif_q <= pif_q + ID_W'(1);
			end

			if (take_item) begin
				merged_q <= 1'b0;
			end else if (merge_end) begin
				merged_q <= 1'b1;
			end

			if (merge_start) begin
				k_q <= '0;
			end else if (pair_step) begin
				k_q <= k_q + CNT_W'(1);
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			req_q <= req_t'(in_ch.req_type);
			fid_q <= in_ch.file_id;
			res_q <= in_ch.resident;
			idx_q <= in_ch.bucket_index;
		end
		if (merge_start) begin
			npairs_q <= npairs_sum[CNT_W:1];
		end
		if (capture_a) begin
			a_q <= rdata_eff;
		end
		if (state_q == ST_EXEC) begin
			iv_q     <= read_ok;
			rd_rec_q <= read_ok ? rdata_eff : '0;
		end
		if (load_out) begin
			out_count_q <= used_q;
			out_cap_q   <= cap_q;
			out_iv_q    <= iv_q;
			out_rec_q   <= rd_rec_q;
			out_last_q  <= cur_file_q;
		end
	end

	assign out_ch.valid               = out_valid_q;
	assign out_ch.bucket_count        = out_count_q;
	assign out_ch.bucket_capacity     = out_cap_q;
	assign out_ch.index_valid         = out_iv_q;
	assign out_ch.bucket_pages        = out_rec_q.pages;
	assign out_ch.bucket_resident     = out_rec_q.resid;
	assign out_ch.bucket_files        = out_rec_q.files;
	assign out_ch.bucket_start_file   = out_rec_q.sfile;
	assign out_ch.bucket_start_offset = out_rec_q.soff;
	assign out_ch.bucket_has_start    = out_rec_q.known;
	assign out_ch.last_file_seen      = out_last_q;
endmodule

// File: hdl/arb_checker.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer checker
// Port-level properties of the bucketer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "adaptive_residency_bucketer_top_defines.svh"

module arb_checker #(
	parameter int CNT_W = arb_pkg::DEFAULT_CNT_W
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [CNT_W-1:0]            bucket_count,
	input logic [arb_pkg::CNT48_W-1:0] capacity
);
	import arb_pkg::*;

	// a result waiting for transfer is not withdrawn
	`ARB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

	// one request at a time: no transfer on the cycle after a transfer
	`ARB_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")

	// at least one bucket and a non-zero capacity in every result
	`ARB_ASSERT(a_result_sane, out_valid |-> (bucket_count != '0 && capacity != '0), "empty result")

	`ARB_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")
endmodule

bind adaptive_residency_bucketer_top arb_checker #(
	.CNT_W(CNT_W)
) u_arb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.bucket_count(out_ch.bucket_count),
	.capacity    (out_ch.bucket_capacity)
);

// File: tb/tb_adaptive_residency_bucketer_top.sv
// ----------------------------------------------------------------------------
// Adaptive residency bucketer testbench
// Drives file-start, page, read and unused requests under several limit and
// capacity settings, predicts every result with a behavioural bucket model
// and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_adaptive_residency_bucketer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import arb_pkg::*;

	localparam int          MAXB         = DEFAULT_MAX_BUCKETS;
	localparam int          DEPTH        = MAXB + 1;
	localparam int          STALL_LIMIT  = 5000;
	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	localparam logic [47:0] M48          = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [8:0]  count;
		logic [47:0] cap;
		logic        idx_ok;
		logic [47:0] pages;
		logic [47:0] resid;
		logic [31:0] files;
		logic [31:0] sfile;
		logic [31:0] soff;
		logic        known;
		logic [31:0] last_file;
	} bucket_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	arb_in_if  in_ch ();
	arb_out_if out_ch ();

	adaptive_residency_bucketer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// bucket model state
	logic [47:0] pg_cnt   [0:DEPTH-1];
	logic [47:0] res_cnt  [0:DEPTH-1];
	logic [31:0] file_cnt [0:DEPTH-1];
	logic [31:0] st_file  [0:DEPTH-1];
	logic [31:0] st_off   [0:DEPTH-1];
	logic        st_known [0:DEPTH-1];
	int          n_used;
	logic [47:0] cap;
	logic [31:0] pos_in_file;
	logic [31:0] cur_file;
	logic [31:0] prev_file;
	logic [8:0]  limit_reg;
	logic [31:0] init_pages;

	bucket_result_t expected_results[$];
	int             mismatches;
	int             idle_cycles;
	bit             steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [47:0] add48(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? M48 : s[47:0];
	endfunction

	function automatic logic [31:0] add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [47:0] reload_cap();
		return (init_pages == 32'd0) ? 48'd1 : {16'd0, init_pages};
	endfunction

	function automatic int merge_threshold();
		int l;
		l = limit_reg;
		if (l < 2) l = 2;
		if (l > MAXB) l = MAXB;
		return l;
	endfunction

	function automatic void clear_bucket(int k);
		pg_cnt[k]   = '0;
		res_cnt[k]  = '0;
		file_cnt[k] = '0;
		st_file[k]  = '0;
		st_off[k]   = '0;
		st_known[k] = 1'b0;
	endfunction

	function automatic void model_reset();
		for (int k = 0; k < DEPTH; k++) clear_bucket(k);
		limit_reg   = LIMIT_RESET;
		init_pages  = 32'd1;
		n_used      = 1;
		cap         = reload_cap();
		pos_in_file = '0;
		cur_file    = '0;
		prev_file   = '0;
	endfunction

	// pad an odd count to even unless full, fold neighbours, halve count, double capacity
	function automatic void fold_buckets();
		int a;
		int b;
		if (n_used[0] && n_used < DEPTH) begin
			clear_bucket(n_used);
			n_used++;
		end
		for (int k = 0; 2 * k + 1 < n_used; k++) begin
			a = 2 * k;
			b = 2 * k + 1;
			pg_cnt[k]   = add48(pg_cnt[a], pg_cnt[b]);
			res_cnt[k]  = add48(res_cnt[a], res_cnt[b]);
			file_cnt[k] = add32(file_cnt[a], file_cnt[b]);
			st_file[k]  = st_file[a];
			st_off[k]   = st_off[a];
			st_known[k] = st_known[a];
		end
		n_used = n_used / 2;
		cap = (cap > 48'h7FFF_FFFF_FFFF) ? M48 : {cap[46:0], 1'b0};
	endfunction

	function automatic bucket_result_t account_request(logic [1:0] kind, logic [31:0] fid,
			logic res, logic [8:0] idx);
		bucket_result_t r;
		int last;
		r = '{default: '0};
		case (kind)
			REQ_FILE_START: begin
				last = n_used - 1;
				if (!st_known[last]) begin
					st_file[last]  = fid;
					st_off[last]   = '0;
					st_known[last] = 1'b1;
				end
				file_cnt[last] = add32(file_cnt[last], 32'd1);
				cur_file    = fid;
				prev_file   = fid;
				pos_in_file = '0;
			end
			REQ_PAGE: begin
				last = n_used - 1;
				if (pg_cnt[last] >= cap) begin
					if (n_used >= merge_threshold()) fold_buckets();
					last = n_used - 1;
					if (pg_cnt[last] >= cap && n_used < DEPTH) begin
						last = n_used;
						n_used++;
						clear_bucket(last);
						st_file[last]  = cur_file;
						st_off[last]   = pos_in_file;
						st_known[last] = 1'b1;
					end
				end
				pg_cnt[last]  = add48(pg_cnt[last], 48'd1);
				res_cnt[last] = add48(res_cnt[last], {47'd0, res});
				pos_in_file   = pos_in_file + 32'd1;
			end
			REQ_READ: begin
				if (idx < n_used && idx < DEPTH) begin
					r.idx_ok = 1'b1;
					r.pages  = pg_cnt[idx];
					r.resid  = res_cnt[idx];
					r.files  = file_cnt[idx];
					r.sfile  = st_file[idx];
					r.soff   = st_off[idx];
					r.known  = st_known[idx];
				end
			end
			default: ;
		endcase
		r.count     = 9'(n_used);
		r.cap       = cap;
		r.last_file = prev_file;
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t which, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(posedge clk);
		if (which == REG_BUCKET_LIMIT) begin
			limit_reg = value[8:0];
		end else begin
			init_pages = value;
			cap = reload_cap();
		end
	endtask

	task automatic configure(logic [8:0] lim, logic [31:0] pages);
		write_reg(REG_BUCKET_LIMIT, {23'd0, lim});
		write_reg(REG_INIT_PAGES, pages);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(logic [1:0] kind, logic [31:0] fid, logic res, logic [8:0] idx);
		while (!steady && $urandom_range(0, 99) < 35) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.req_type     <= kind;
		in_ch.file_id      <= fid;
		in_ch.resident     <= res;
		in_ch.bucket_index <= idx;
		do @(posedge clk); while (!in_ch.ready);
		expected_results.push_back(account_request(kind, fid, res, idx));
	endtask

	// wait for every expected result; the block is idle once the last one is out
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_file_id();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_traffic(int n, int page_pct);
		logic [1:0]  kind;
		logic [8:0]  idx;
		int          q;
		for (int i = 0; i < n; i++) begin
			q = $urandom_range(0, 9);
			if ($urandom_range(0, 99) < page_pct) kind = REQ_PAGE;
			else if (q < 5)                       kind = REQ_READ;
			else if (q < 9)                       kind = REQ_FILE_START;
			else                                  kind = REQ_UNUSED;
			if ($urandom_range(0, 4) == 0) idx = 9'($urandom_range(0, 511));
			else                           idx = 9'($urandom_range(0, n_used - 1));
			send_item(kind, pick_file_id(), 1'($urandom()), idx);
		end
	endtask

	task automatic test_corner_items();
		// page ahead of any file start lands in bucket 0 against file 0
		send_item(REQ_PAGE, 32'hFFFF_FFFF, 1'b1, 9'h1FF);
		send_item(REQ_FILE_START, 32'hFFFF_FFFF, 1'b1, 9'h1FF);
		send_item(REQ_READ, 32'hFFFF_FFFF, 1'b1, 9'd0);
		send_item(REQ_PAGE, 32'd0, 1'b0, 9'd0);
		send_item(REQ_PAGE, 32'd0, 1'b1, 9'd0);
		send_item(REQ_FILE_START, 32'd0, 1'b0, 9'd0);
		send_item(REQ_PAGE, 32'hA5A5_5A5A, 1'b0, 9'h155);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd3);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd1);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd2);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd4);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd256);
		send_item(REQ_READ, 32'hFFFF_FFFF, 1'b1, 9'h1FF);
		send_item(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, 9'd1);
		send_item(REQ_UNUSED, 32'd0, 1'b0, 9'h0AA);
		send_item(REQ_FILE_START, 32'h5A5A_A5A5, 1'b1, 9'h0AA);
		send_item(REQ_PAGE, 32'd0, 1'b1, 9'd0);
		send_item(REQ_READ, 32'd0, 1'b1, 9'd4);
		send_item(REQ_READ, 32'd0, 1'b0, 9'd3);
		drain();
	endtask

	// limit 0 clamps to 2, zero capacity acts as 1: merges begin with the early pages
	task automatic test_tiny_limit();
		configure(9'd0, 32'd0);
		random_traffic(180, 60);
		drain();
	endtask

	task automatic test_small_buckets();
		configure(9'd3, 32'd2);
		random_traffic(200, 60);
		drain();
	endtask

	// 511 clamps to MAX_BUCKETS (256); long page runs reach the widest merge pass
	task automatic test_full_depth_merge();
		configure(9'h1FF, 32'd1);
		steady = 1'b1;
		random_traffic(200, 88);
		steady = 1'b0;
		random_traffic(200, 88);
		drain();
	endtask

	task automatic test_huge_capacity();
		configure(9'd256, 32'hFFFF_FFFF);
		random_traffic(120, 60);
		drain();
	endtask

	task automatic test_mixed_limits();
		configure(9'd1, 32'd7);
		random_traffic(150, 70);
		drain();
		configure(9'd2, 32'd5);
		random_traffic(150, 70);
		drain();
	endtask

	function automatic string field_diff(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) return $sformatf(" %s exp=%0h got=%0h", name, want, got);
		return "";
	endfunction

	// output side: random back-pressure, none during the steady stretch
	always @(posedge clk) begin
		out_ch.ready <= steady || ($urandom_range(0, 99) >= 35);
	end

	always @(posedge clk) begin : check_results
		bucket_result_t want;
		string          diffs;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
			end else begin
				want = expected_results.pop_front();
				diffs = {
					field_diff("bucket_count", want.count, out_ch.bucket_count),
					field_diff("bucket_capacity", want.cap, out_ch.bucket_capacity),
					field_diff("index_valid", want.idx_ok, out_ch.index_valid),
					field_diff("bucket_pages", want.pages, out_ch.bucket_pages),
					field_diff("bucket_resident", want.resid, out_ch.bucket_resident),
					field_diff("bucket_files", want.files, out_ch.bucket_files),
					field_diff("bucket_start_file", want.sfile, out_ch.bucket_start_file),
					field_diff("bucket_start_offset", want.soff, out_ch.bucket_start_offset),
					field_diff("bucket_has_start", want.known, out_ch.bucket_has_start),
					field_diff("last_file_seen", want.last_file, out_ch.last_file_seen)
				};
				if (diffs != "") begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch at %0t:%s", $realtime, diffs);
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_adaptive_residency_bucketer_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_BUCKET_LIMIT;
		cfg_wdata          <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.req_type     <= REQ_FILE_START;
		in_ch.file_id      <= '0;
		in_ch.resident     <= 1'b0;
		in_ch.bucket_index <= '0;
		steady      = 1'b0;
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_items();
		test_tiny_limit();
		test_small_buckets();
		test_full_depth_merge();
		test_huge_capacity();
		test_mixed_limits();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb_adaptive_residency_bucketer_top: PASS");
		end else begin
			$display("tb_adaptive_residency_bucketer_top: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/arb_pkg.sv
hdl/arb_in_if.sv
hdl/arb_out_if.sv
hdl/arb_ram.sv
hdl/arb_alu.sv
hdl/adaptive_residency_bucketer_top.sv
hdl/arb_checker.sv
tb/tb_adaptive_residency_bucketer_top.sv
